[src/rpnc_pkg.sv]
// Package for the reverse Polish stack calculator.
// Holds operation and status codes and the cell control struct.
// No dependencies; used by rpnc_cell and rpn_stack_calculator_core.
package rpnc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_ADD    = 2'd1,
    OP_MUL    = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Control for one stack cell: load a new value, and pick it from the
  // neighbour below (towards the bottom) rather than the one above.
  typedef struct packed {
    logic load;
    logic from_next;
  } cell_ctrl_t;

endpackage

[src/rpnc_cell.sv]
// One stack cell of the reverse Polish stack calculator.
// Holds one entry and loads it from either neighbour; uses rpnc_pkg.
module rpnc_cell
  import rpnc_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] prev_i,
  input  logic [DataW-1:0] next_i,
  output logic [DataW-1:0] q_o
);

  logic [DataW-1:0] entry_q;
  logic [DataW-1:0] entry_d;

  assign entry_d = ctrl_i.from_next ? next_i : prev_i;

  // Entries are undefined until written, so no reset is needed here.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

[src/rpn_stack_calculator_core.sv]
// Top level of the reverse Polish stack calculator.
// Instantiates a row of rpnc_cell stack cells; uses rpnc_pkg.
//
// Channel  | Dir | tdata                      | tuser        | tlast
// ---------+-----+----------------------------+--------------+---------
// s_axis   | in  | [31:0] value               | [1:0] op     | -
// m_axis   | out | [31:0] result_value        | [1:0] status | is_final
//
// Cycles: one item per cycle unless a result is held. Each item is evaluated in the cycle it is
// accepted, using only the two top cells and one 32x32 multiplier, and the
// result is captured in the output register on the same edge.
// The stack itself is a row of cells with the top entry in cell 0; a push
// shifts every cell down by one, a finish shifts every cell up, and an add or
// multiply writes the result into cell 0 while the rest shift up.
// Reset clears the entry count and the output valid flag; cell contents are
// undefined until pushed, and are never read before that.
// Stalls: the input is ready whenever the output register is empty or is
// being taken in the same cycle, so a held result stalls only the next item.
module rpn_stack_calculator_core
  import rpnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input items.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]       s_axis_tuser_i,   // [1:0] op
  // Result items.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // [31:0] result_value
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  output logic             m_axis_tlast_o    // is_final
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] Two  = CntW'(2);

  // Handshake.
  logic in_fire;
  logic out_valid_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  op_e op;
  assign op = op_e'(s_axis_tuser_i);

  // Stack occupancy.
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  // Cell outputs; cell 0 is the top of the stack.
  logic [DataW-1:0] cell_w [STACK_DEPTH];

  // Arithmetic on the two top entries. Both operations commute, and both
  // keep only the low 32 bits, so the product wraps like the sum.
  logic [DataW-1:0] top_a;
  logic [DataW-1:0] top_b;
  logic [DataW-1:0] sum_w;
  logic [DataW-1:0] prod_w;

  assign top_a  = cell_w[0];
  assign top_b  = cell_w[1];
  assign sum_w  = top_a + top_b;
  assign prod_w = top_a * top_b;

  // Decode the item: what is reported and how the stack moves.
  logic             op_ok;
  logic             shift_down;   // push
  logic             merge_top;    // add or multiply
  logic [DataW-1:0] new_top;
  logic [DataW-1:0] res_value;
  status_e          res_status;
  logic             res_final;

  always_comb begin
    op_ok      = 1'b0;
    shift_down = 1'b0;
    merge_top  = 1'b0;
    new_top    = s_axis_tdata_i;
    res_value  = '0;
    res_status = ST_OK;
    res_final  = 1'b0;
    count_d    = count_q;
    case (op)
      OP_PUSH: begin
        if (count_q >= Full) begin
          res_status = ST_OVERFLOW;
        end else begin
          op_ok      = 1'b1;
          shift_down = 1'b1;
          res_value  = s_axis_tdata_i;
          count_d    = count_q + CntW'(1);
        end
      end
      OP_ADD, OP_MUL: begin
        if (count_q < Two) begin
          res_status = ST_UNDERFLOW;
        end else begin
          op_ok     = 1'b1;
          merge_top = 1'b1;
          new_top   = (op == OP_ADD) ? sum_w : prod_w;
          res_value = new_top;
          count_d   = count_q - CntW'(1);
        end
      end
      OP_FINISH: begin
        res_final = 1'b1;
        if (count_q == '0) begin
          res_status = ST_UNDERFLOW;
        end else begin
          op_ok     = 1'b1;
          res_value = top_a;
          count_d   = count_q - CntW'(1);
        end
      end
      default: begin
        res_status = ST_UNDERFLOW;
      end
    endcase
  end

  // Cell control: cell 0 takes the new top on a push or a merge and the
  // entry below on a finish; every other cell shifts down on a push and up
  // otherwise.
  cell_ctrl_t top_ctrl;
  cell_ctrl_t rest_ctrl;

  assign top_ctrl.load       = in_fire && op_ok;
  assign top_ctrl.from_next  = !(shift_down || merge_top);
  assign rest_ctrl.load      = in_fire && op_ok;
  assign rest_ctrl.from_next = !shift_down;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] prev_w;
    logic [DataW-1:0] next_w;
    cell_ctrl_t       ctrl_w;

    if (i == 0) begin : g_top
      assign prev_w = new_top;
      assign ctrl_w = top_ctrl;
    end else begin : g_inner
      assign prev_w = cell_w[i-1];
      assign ctrl_w = rest_ctrl;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_w = '0;
    end else begin : g_link
      assign next_w = cell_w[i+1];
    end

    rpnc_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_w),
      .prev_i (prev_w),
      .next_i (next_w),
      .q_o    (cell_w[i])
    );
  end

  // Occupancy and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (s_axis_tready_o) begin
        out_valid_q <= in_fire;
      end
    end
  end

  // Output payload register.
  logic [DataW-1:0] out_value_q;
  logic [1:0]       out_status_q;
  logic             out_final_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
      out_final_q  <= res_final;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_final_q;

  // Checks.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("stack count beyond depth");

  a_push_lands_on_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OP_PUSH && count_q < Full) |=> cell_w[0] == $past(s_axis_tdata_i))
    else $error("pushed value not on top of stack");

  a_finish_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OP_FINISH) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("finish did not give a final result");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |-> m_axis_tdata_o == '0)
    else $error("error result carries a value");

  a_error_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !op_ok) |=> $stable(count_q))
    else $error("failed operation changed the stack");

endmodule

[verif/rpn_stack_calculator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator_core: drives push, add, multiply and
// finish items under random idling and compares every result with a stack predictor.
// Depends on rpnc_pkg and the rpn_stack_calculator_core RTL only.
module rpn_stack_calculator_core_tb;
  import rpnc_pkg::*;

  localparam int unsigned StackDepth = 16;
  // Cycles without any handshake on either side before the run is declared hung.
  localparam int unsigned HangLimit  = 4000;
  localparam int unsigned RandomItemsPerPhase = 200;
  localparam int unsigned LongHoldCycles = 150;

  // One expected result item.
  typedef struct {
    logic [DataW-1:0] value;
    status_e          status;
    logic             is_last;
  } rpn_result_t;

  // Keeps its own copy of the stack, works out the result of every accepted
  // item and holds those results until the block produces them.
  class rpn_result_tracker;
    logic [DataW-1:0] cells [StackDepth];
    int unsigned      depth;
    rpn_result_t      pending [$];
    int unsigned      mismatches;

    function new();
      depth      = 0;
      mismatches = 0;
    endfunction

    function void note_item(op_e op, logic [DataW-1:0] operand);
      rpn_result_t res;
      res.value   = '0;
      res.status  = ST_OK;
      res.is_last = (op == OP_FINISH);
      case (op)
        OP_PUSH: begin
          if (depth >= StackDepth) begin
            res.status = ST_OVERFLOW;
          end else begin
            cells[depth] = operand;
            depth++;
            res.value = operand;
          end
        end
        OP_ADD, OP_MUL: begin
          if (depth < 2) begin
            res.status = ST_UNDERFLOW;
          end else begin
            // Both operations wrap at 32 bits; the assignment width truncates.
            if (op == OP_ADD) res.value = cells[depth-1] + cells[depth-2];
            else              res.value = cells[depth-1] * cells[depth-2];
            depth--;
            cells[depth-1] = res.value;
          end
        end
        default: begin
          if (depth == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            depth--;
            res.value = cells[depth];
          end
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [DataW-1:0] got_value, logic [1:0] got_status,
                               logic got_last);
      rpn_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: value %h status %0d last %b",
                   got_value, got_status, got_last);
        return;
      end
      want = pending.pop_front();
      if (got_value !== want.value || got_status !== want.status ||
          got_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h status %s last %b, got value %h status %0d last %b",
                   want.value, want.status.name(), want.is_last,
                   got_value, got_status, got_last);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i = '0;   // [31:0] value
  logic [1:0]       s_axis_tuser_i = '0;   // [1:0] op
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DataW-1:0] m_axis_tdata_o;        // [31:0] result_value
  logic [1:0]       m_axis_tuser_o;        // [1:0] status
  logic             m_axis_tlast_o;        // is_final

  rpn_result_tracker tracker = new();

  // Idling controls, changed only just after a rising edge.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_cycles     = 0;
  // Stack depth as the stimulus side expects it, used to steer the random part.
  int unsigned gen_depth = 0;
  int unsigned quiet_cycles = 0;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor and watchdog. Inputs are noted before the output is checked so that
  // the ordering holds even for a block with no output register.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        tracker.note_item(op_e'(s_axis_tuser_i), s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HangLimit) begin
        $display("timeout: no item moved for %0d cycles", HangLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side. A long hold-off, when requested, is counted down here; otherwise
  // the ready line stalls at random according to the current phase.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Operand values weighted towards the corners of the 32-bit range.
  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return DataW'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  // Offers one item, starting and ending at a falling edge. Random idle cycles are
  // inserted ahead of it, and it stays on the bus until the block takes it.
  task automatic offer(op_e op, logic [DataW-1:0] operand);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = $urandom();
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = operand;
    s_axis_tuser_i  = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    case (op)
      OP_PUSH:        if (gen_depth < StackDepth) gen_depth++;
      OP_ADD, OP_MUL: if (gen_depth >= 2) gen_depth--;
      default:        if (gen_depth > 0) gen_depth--;
    endcase
  endtask

  // Changes the idling mix. The valid line is dropped first so that the item
  // already taken is not offered a second time while we wait for the edge.
  task automatic set_phase(int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned hold);
    s_axis_tvalid_i = 1'b0;
    @(posedge clk_i);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    hold_cycles     = hold;
    @(negedge clk_i);
  endtask

  // Mostly well-formed evaluations steered by the expected depth, with some
  // noise items and the odd run of pushes that drives the stack into overflow.
  task automatic run_random(int unsigned count);
    int unsigned roll;
    int unsigned sent;
    op_e         op;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        while (gen_depth < StackDepth && sent < count) begin
          offer(OP_PUSH, rand_value());
          sent++;
        end
        op = OP_PUSH;
      end else if (roll < 11) begin
        op = op_e'($urandom_range(3));
      end else if (gen_depth < 2) begin
        op = (gen_depth == 1 && roll < 25) ? OP_FINISH : OP_PUSH;
      end else if (gen_depth >= StackDepth) begin
        op = (roll < 20) ? OP_PUSH : op_e'($urandom_range(3, 1));
      end else begin
        roll = $urandom_range(99);
        if (roll < 50)      op = OP_PUSH;
        else if (roll < 70) op = OP_ADD;
        else if (roll < 88) op = OP_MUL;
        else                op = OP_FINISH;
      end
      offer(op, rand_value());
      sent++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty-stack underflows, one-entry underflow, wrapping sum
    // and product at the extremes, a successful finish, then a full stack and
    // a push onto it.
    offer(OP_FINISH, 32'hFFFF_FFFF);
    offer(OP_ADD,    32'h0000_0000);
    offer(OP_PUSH,   32'h7FFF_FFFF);
    offer(OP_MUL,    32'h1234_5678);
    offer(OP_PUSH,   32'h7FFF_FFFF);
    offer(OP_ADD,    32'h0000_0000);
    offer(OP_PUSH,   32'h8000_0000);
    offer(OP_MUL,    32'h0000_0000);
    offer(OP_PUSH,   32'hFFFF_FFFF);
    offer(OP_PUSH,   32'h0000_0000);
    offer(OP_FINISH, 32'h0000_0000);
    while (gen_depth < StackDepth) offer(OP_PUSH, rand_value());
    offer(OP_PUSH,   32'hA5A5_A5A5);
    offer(OP_FINISH, 32'h0000_0000);

    // No idling, but the receiver first holds off for a long stretch so that the
    // output register fills and the input stalls while items are on offer.
    set_phase(0, 0, LongHoldCycles);
    run_random(RandomItemsPerPhase);
    set_phase(63, 0, 0);
    run_random(RandomItemsPerPhase);
    set_phase(0, 63, 0);
    run_random(RandomItemsPerPhase);
    set_phase(37, 37, 0);
    run_random(RandomItemsPerPhase);

    s_axis_tvalid_i = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
